// ===== hw/rtl/sipf_pkg.sv =====
// Shared types and constants for the SIP stream message framer.
// No dependencies; used by the channel interfaces and the framer top level.
package sipf_pkg;

  // Framing phase codes
  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Length conversion state codes
  localparam logic [1:0] CV_WS     = 2'd0;
  localparam logic [1:0] CV_DIGITS = 2'd1;
  localparam logic [1:0] CV_DONE   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Two header bytes that precede the final CR LF of a blank line
  localparam logic [15:0] CRLF_PAIR = 16'h0D0A;

  localparam int          LEN_W      = 13;
  localparam int          VAL_W      = 14;
  localparam logic [13:0] VALUE_MAX  = 14'h3FFF;
  localparam logic [3:0]  PREFIX_LEN = 4'd14;
  localparam logic [3:0]  LPOS_MAX   = 4'd15;
  localparam logic [12:0] CFG_RESET  = 13'h1FFF;

  // Buffer size the message limit is clipped to
  localparam int          BUFFER_BYTES = 8192;
  localparam int          BUF_LIMIT_I  = (BUFFER_BYTES - 1 > 8191) ? 8191 : BUFFER_BYTES - 1;
  localparam logic [12:0] BUF_LIMIT    = BUF_LIMIT_I[12:0];

  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [VAL_W-1:0] val_t;

  // Characters of the length header name, by position in the line
  function automatic byte_t prefix_char(input logic [3:0] pos);
    byte_t c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/sipf_if.sv =====
// Valid/ready channel interfaces of the SIP stream message framer.
// Depends on sipf_pkg for payload types.
interface sipf_in_if;
  logic            valid;
  logic            ready;
  sipf_pkg::byte_t data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface sipf_out_if;
  logic            valid;
  logic            ready;
  sipf_pkg::byte_t out_byte;
  logic            last_of_message;
  sipf_pkg::len_t  message_length;
  logic            status;
  modport source (output valid, output out_byte, output last_of_message,
                  output message_length, output status, input ready);
  modport sink   (input valid, input out_byte, input last_of_message,
                  input message_length, input status, output ready);
endinterface

interface sipf_cfg_if;
  logic           valid;
  logic           ready;
  sipf_pkg::len_t max_message_len;
  modport source (output valid, output max_message_len, input ready);
  modport sink   (input valid, input max_message_len, output ready);
endinterface

// ===== hw/rtl/sip_stream_message_framer.sv =====
// SIP stream message framer: top level, the whole framing datapath.
// Depends on sipf_pkg and the channel interfaces in sipf_if.sv.
//
// Usage:
//   in_if  : one stream byte per transfer (data_byte).
//   out_if : one result per message byte: the byte, last_of_message with the
//            message byte count in message_length, or status 1 on overflow
//            (message dropped, framer restarts). Whitespace ahead of a message
//            gives no result.
//   cfg_if : writes max_message_len; always ready. Write it only while idle.
// Throughput: one byte per cycle while out_if.ready is high; a byte is held in
//   the input register, then the per-byte update of the header scanner and the
//   x10 length accumulator sits between the input register and the output
//   register, which holds its result.
// Reset (rst_n low, synchronous): framer skips leading whitespace, all
//   counters clear, max_message_len returns to 8191, no result pending.
// Receiver stall: the result holds in the output register; one further byte
//   is taken into the input register and waits there, then in_if.ready drops
//   until out_if.ready returns.
module sip_stream_message_framer #(
  parameter int LENGTH_CHARS = 21
) (
  input  logic     clk,
  input  logic     rst_n,
  sipf_in_if.sink  in_if,
  sipf_out_if.source out_if,
  sipf_cfg_if.sink cfg_if
);

  localparam int KW = $clog2(LENGTH_CHARS + 1);
  localparam logic [KW-1:0] KEEP_MAX = KW'(LENGTH_CHARS);

  // Configuration
  sipf_pkg::len_t max_len_r;
  sipf_pkg::len_t limit;

  // Input register
  logic            in_full_r, in_full_nxt;
  sipf_pkg::byte_t in_byte_r;

  // Framer state
  logic [1:0]       phase_r, phase_nxt;
  logic [23:0]      recent_r, recent_nxt;
  sipf_pkg::len_t   msg_cnt_r, msg_cnt_nxt;
  logic [3:0]       lpos_r, lpos_nxt;
  logic             pmatch_r, pmatch_nxt;
  logic             lrow_r, lrow_nxt;
  logic             lknown_r, lknown_nxt;
  sipf_pkg::val_t   lval_r, lval_nxt;
  logic [1:0]       conv_r, conv_nxt;
  logic [KW-1:0]    kept_r, kept_nxt;
  logic             lneg_r, lneg_nxt;
  sipf_pkg::val_t   body_r, body_nxt;

  // Output register
  logic            out_valid_r;
  sipf_pkg::byte_t out_byte_r;
  logic            out_last_r, out_last_nxt;
  sipf_pkg::len_t  out_len_r, out_len_nxt;
  logic            out_stat_r, out_stat_nxt;

  logic            has_result;
  logic            done;
  logic            consume;
  logic            try_digit;
  logic [17:0]     prod;
  sipf_pkg::byte_t b;

  assign b = in_byte_r;
  assign limit = (max_len_r < sipf_pkg::BUF_LIMIT) ? max_len_r : sipf_pkg::BUF_LIMIT;

  // Per-byte framing update
  always_comb begin
    phase_nxt    = phase_r;
    recent_nxt   = recent_r;
    msg_cnt_nxt  = msg_cnt_r;
    lpos_nxt     = lpos_r;
    pmatch_nxt   = pmatch_r;
    lrow_nxt     = lrow_r;
    lknown_nxt   = lknown_r;
    lval_nxt     = lval_r;
    conv_nxt     = conv_r;
    kept_nxt     = kept_r;
    lneg_nxt     = lneg_r;
    body_nxt     = body_r;
    has_result   = 1'b1;
    done         = 1'b0;
    try_digit    = 1'b0;
    prod         = 18'd0;
    out_last_nxt = 1'b0;
    out_len_nxt  = '0;
    out_stat_nxt = 1'b0;

    if (phase_r == sipf_pkg::PH_SKIP &&
        (b == sipf_pkg::CH_SP || b == sipf_pkg::CH_TAB ||
         b == sipf_pkg::CH_CR || b == sipf_pkg::CH_LF)) begin
      // Drop whitespace ahead of a message
      has_result = 1'b0;
    end else begin
      msg_cnt_nxt = msg_cnt_r + 1'b1;
      if (phase_r != sipf_pkg::PH_BODY) begin
        phase_nxt = sipf_pkg::PH_HEAD;
        if (b == sipf_pkg::CH_LF) begin
          if (recent_r[7:0] == sipf_pkg::CH_CR) begin
            if (lrow_r) begin
              lknown_nxt = 1'b1;
            end else if (recent_r[23:8] == sipf_pkg::CRLF_PAIR) begin
              // Blank line: headers end here
              if (lknown_r && lval_r == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt = sipf_pkg::PH_BODY;
              end
            end
          end
          lpos_nxt   = '0;
          pmatch_nxt = 1'b1;
          lrow_nxt   = 1'b0;
        end else begin
          if (lrow_r) begin
            // Collect length characters, atoi style
            if (b != sipf_pkg::CH_COLON && b != sipf_pkg::CH_SP &&
                b != sipf_pkg::CH_CR && kept_r < KEEP_MAX) begin
              kept_nxt = kept_r + 1'b1;
              if (conv_r == sipf_pkg::CV_WS) begin
                if (b == sipf_pkg::CH_PLUS || b == sipf_pkg::CH_MINUS) begin
                  lneg_nxt = (b == sipf_pkg::CH_MINUS);
                  conv_nxt = sipf_pkg::CV_DIGITS;
                end else if (b != sipf_pkg::CH_TAB && b != sipf_pkg::CH_VT &&
                             b != sipf_pkg::CH_FF) begin
                  conv_nxt  = sipf_pkg::CV_DIGITS;
                  try_digit = 1'b1;
                end
              end else if (conv_r == sipf_pkg::CV_DIGITS) begin
                try_digit = 1'b1;
              end
              if (try_digit) begin
                if (b >= sipf_pkg::CH_ZERO && b <= sipf_pkg::CH_NINE) begin
                  prod = ({4'd0, lval_r} << 3) + ({4'd0, lval_r} << 1) + {14'd0, b[3:0]};
                  lval_nxt = (prod > {4'd0, sipf_pkg::VALUE_MAX}) ?
                             sipf_pkg::VALUE_MAX : prod[13:0];
                end else begin
                  conv_nxt = sipf_pkg::CV_DONE;
                end
              end
            end
          end else if (lpos_r < sipf_pkg::PREFIX_LEN &&
                       b != sipf_pkg::prefix_char(lpos_r)) begin
            pmatch_nxt = 1'b0;
          end
          if (lpos_r < sipf_pkg::LPOS_MAX) begin
            lpos_nxt = lpos_r + 1'b1;
          end
          // Open the length line once the full name has matched
          if (!lrow_r && !lknown_r && lpos_nxt == sipf_pkg::PREFIX_LEN && pmatch_nxt) begin
            lrow_nxt = 1'b1;
            lval_nxt = '0;
            lneg_nxt = 1'b0;
            conv_nxt = sipf_pkg::CV_WS;
            kept_nxt = '0;
          end
        end
        recent_nxt = {recent_r[15:0], b};
      end else begin
        if (body_r < sipf_pkg::VALUE_MAX) begin
          body_nxt = body_r + 1'b1;
        end
        if (lknown_r && !lneg_r && body_nxt == lval_r) begin
          done = 1'b1;
        end
      end

      if (done) begin
        out_last_nxt = 1'b1;
        out_len_nxt  = msg_cnt_nxt;
      end else if (msg_cnt_nxt >= limit) begin
        out_stat_nxt = 1'b1;
      end

      // Restart after completion or overflow
      if (done || msg_cnt_nxt >= limit) begin
        phase_nxt   = sipf_pkg::PH_SKIP;
        recent_nxt  = '0;
        msg_cnt_nxt = '0;
        lpos_nxt    = '0;
        pmatch_nxt  = 1'b1;
        lrow_nxt    = 1'b0;
        lknown_nxt  = 1'b0;
        lval_nxt    = '0;
        conv_nxt    = sipf_pkg::CV_WS;
        kept_nxt    = '0;
        lneg_nxt    = 1'b0;
        body_nxt    = '0;
      end
    end
  end

  // Advance the held byte when its result has a place to go
  assign consume = in_full_r && (!has_result || !out_valid_r || out_if.ready);
  assign in_if.ready = !in_full_r || consume;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_if.valid && in_if.ready) begin
      in_full_nxt = 1'b1;
    end else if (consume) begin
      in_full_nxt = 1'b0;
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= sipf_pkg::CFG_RESET;
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= sipf_pkg::PH_SKIP;
      recent_r    <= '0;
      msg_cnt_r   <= '0;
      lpos_r      <= '0;
      pmatch_r    <= 1'b1;
      lrow_r      <= 1'b0;
      lknown_r    <= 1'b0;
      lval_r      <= '0;
      conv_r      <= sipf_pkg::CV_WS;
      kept_r      <= '0;
      lneg_r      <= 1'b0;
      body_r      <= '0;
    end else begin
      if (cfg_if.valid) begin
        max_len_r <= cfg_if.max_message_len;
      end
      in_full_r <= in_full_nxt;
      if (consume) begin
        phase_r  <= phase_nxt;
        recent_r <= recent_nxt;
        msg_cnt_r <= msg_cnt_nxt;
        lpos_r   <= lpos_nxt;
        pmatch_r <= pmatch_nxt;
        lrow_r   <= lrow_nxt;
        lknown_r <= lknown_nxt;
        lval_r   <= lval_nxt;
        conv_r   <= conv_nxt;
        kept_r   <= kept_nxt;
        lneg_r   <= lneg_nxt;
        body_r   <= body_nxt;
      end
      if (consume && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
    end
    if (consume && has_result) begin
      out_byte_r <= b;
      out_last_r <= out_last_nxt;
      out_len_r  <= out_len_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_byte        = out_byte_r;
  assign out_if.last_of_message = out_last_r;
  assign out_if.message_length  = out_len_r;
  assign out_if.status          = out_stat_r;

endmodule

// ===== hw/rtl/sipf_checker.sv =====
// Port-level assertions for the SIP stream message framer, bound to the top.
// Depends on sipf_pkg and sip_stream_message_framer.
module sipf_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input sipf_pkg::byte_t out_byte,
  input logic            out_last,
  input sipf_pkg::len_t  out_len,
  input logic            out_status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last) &&
    $stable(out_len) && $stable(out_status))
    else $error("stalled result changed");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_status && out_len != '0)
    else $error("completion with overflow or zero length");

  a_ovf_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_last && out_len == '0)
    else $error("overflow result carries completion fields");

  a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_len == '0)
    else $error("message length outside completion");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind sip_stream_message_framer sipf_checker u_sipf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .out_last   (out_if.last_of_message),
  .out_len    (out_if.message_length),
  .out_status (out_if.status)
);
